FILE: src/wpt_pkg.sv
// Shared widths, codes and types for the waypoint table with cursor.
// No dependencies; every other file of the block but wpt_ram uses this package.
package wpt_pkg;

  localparam int NUM_W      = 8;
  localparam int WHOLE_W    = 8;
  localparam int FRAC_W     = 20;
  localparam int MICRO_W    = 28;
  localparam int COUNT_W    = 9;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;

  localparam int TABLE_SLOTS = 256;
  localparam int CHUNK_BITS  = 32;
  localparam int CHUNK_W     = $clog2(CHUNK_BITS);
  localparam int CHUNK_SEL_W = NUM_W - CHUNK_W;
  localparam logic [CHUNK_SEL_W-1:0] CHUNK_LAST = CHUNK_SEL_W'(TABLE_SLOTS / CHUNK_BITS - 1);

  localparam int KEY_COUNT_DEF  = 256;
  localparam int FRAC_SCALE_DEF = 1000000;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_PREV   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_MISS  = 3'd2,
    ST_END   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [NUM_W-1:0] index;
  } scan_res_t;

endpackage

FILE: src/wpt_if.sv
// Command and result channels of the waypoint table (valid/ready handshake).
// Depends on wpt_pkg for field widths.
interface wpt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [wpt_pkg::KIND_W-1:0]   kind;
  logic [wpt_pkg::NUM_W-1:0]    point_number;
  logic [wpt_pkg::WHOLE_W-1:0]  lat_whole;
  logic [wpt_pkg::FRAC_W-1:0]   lat_millionths;
  logic [wpt_pkg::WHOLE_W-1:0]  lon_whole;
  logic [wpt_pkg::FRAC_W-1:0]   lon_millionths;

  modport source(output valid, kind, point_number, lat_whole, lat_millionths, lon_whole,
                 lon_millionths, input ready);
  modport sink(input valid, kind, point_number, lat_whole, lat_millionths, lon_whole,
               lon_millionths, output ready);
endinterface

interface wpt_res_if;
  logic                          valid;
  logic                          ready;
  logic [wpt_pkg::STATUS_W-1:0]  status;
  logic [wpt_pkg::MICRO_W-1:0]   latitude_micro;
  logic [wpt_pkg::MICRO_W-1:0]   longitude_micro;
  logic [wpt_pkg::NUM_W-1:0]     cursor_number;
  logic                          cursor_valid;
  logic [wpt_pkg::COUNT_W-1:0]   point_count;

  modport source(output valid, status, latitude_micro, longitude_micro, cursor_number,
                 cursor_valid, point_count, input ready);
  modport sink(input valid, status, latitude_micro, longitude_micro, cursor_number,
               cursor_valid, point_count, output ready);
endinterface

FILE: src/wpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpt_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/wpt_scan.sv
// Chunked search of the presence map for the nearest set bit above or below
// a start number, one 32-bit chunk a cycle. Depends on wpt_pkg.
module wpt_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                dir_up,
  input  logic [wpt_pkg::NUM_W-1:0]           from,
  input  logic [wpt_pkg::TABLE_SLOTS-1:0]     map,
  output wpt_pkg::scan_res_t                  result
);

  localparam int CB = wpt_pkg::CHUNK_BITS;
  localparam int CW = wpt_pkg::CHUNK_W;
  localparam int SW = wpt_pkg::CHUNK_SEL_W;

  logic          busy;
  logic          first;
  logic          dir_q;
  logic [SW-1:0] chunk;
  logic [CW-1:0] bitpos;
  logic [CB-1:0] chunk_bits;
  logic [CB-1:0] mask;
  logic [CB-1:0] cand;
  logic [CW-1:0] pos;
  logic          hit;
  logic          last;

  always_comb begin
    chunk_bits = map[{chunk, CW'(0)} +: CB];
    if (!first) begin
      mask = '1;
    end else if (dir_q) begin
      mask = ~(((CB)'(2) << bitpos) - (CB)'(1));
    end else begin
      mask = ((CB)'(1) << bitpos) - (CB)'(1);
    end
    cand = chunk_bits & mask;
    hit  = |cand;
    last = dir_q ? (chunk == wpt_pkg::CHUNK_LAST) : (chunk == '0);
    pos  = '0;
    if (dir_q) begin
      for (int j = CB - 1; j >= 0; j--) begin
        if (cand[j]) begin
          pos = CW'(j);
        end
      end
    end else begin
      for (int j = 0; j < CB; j++) begin
        if (cand[j]) begin
          pos = CW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result.done  <= 1'b0;
      result.found <= 1'b0;
      result.index <= '0;
      first        <= 1'b0;
      dir_q        <= 1'b0;
      chunk        <= '0;
      bitpos       <= '0;
    end else if (start) begin
      busy        <= 1'b1;
      result.done <= 1'b0;
      first       <= 1'b1;
      dir_q       <= dir_up;
      chunk       <= from[wpt_pkg::NUM_W-1:CW];
      bitpos      <= from[CW-1:0];
    end else if (busy) begin
      first <= 1'b0;
      if (hit || last) begin
        busy         <= 1'b0;
        result.done  <= 1'b1;
        result.found <= hit;
        result.index <= {chunk, pos};
      end else if (dir_q) begin
        chunk <= chunk + SW'(1);
      end else begin
        chunk <= chunk - SW'(1);
      end
    end
  end

endmodule

FILE: src/waypoint_table_with_cursor.sv
// Waypoint table with cursor: top level, sequencer and coordinate storage.
// Depends on wpt_pkg, wpt_if, wpt_ram and wpt_scan.
//
// Use: items arrive on cmd (valid/ready) and each gives exactly one item on
// res (valid/ready). cmd.ready is high only while the sequencer is idle;
// one item is worked at a time.
// A lookup miss, a refused insert or a cursor move on an empty table goes
// straight to the result; a lookup hit first reads both RAMs, an insert
// writes latitude then longitude and then searches, and a cursor move
// searches. cmd.ready rises in the cycle res.valid rises. How long the
// searches take depends on the presence-map search unit, which examines one
// 32-number chunk per cycle and is shared by the lowest-number check of
// insert and the next/prev cursor moves. Coordinates go through one shared
// multiply-add (whole * FRAC_SCALE + fraction), latitude then longitude,
// and sit in two RAMs with registered read.
// Reset (synchronous, active high) empties the table, clears the cursor and
// the count and drops any pending result; RAM contents are not cleared.
// A result waits in the output register while res.ready is low; a new item
// may be accepted meanwhile, and its result waits in the sequencer until
// the output register is free.
module waypoint_table_with_cursor #(
  parameter int KEY_COUNT  = wpt_pkg::KEY_COUNT_DEF,
  parameter int FRAC_SCALE = wpt_pkg::FRAC_SCALE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wpt_cmd_if.sink   cmd,
  wpt_res_if.source res
);

  localparam int ADDR_W = $clog2(KEY_COUNT);
  localparam int NW     = wpt_pkg::NUM_W;
  localparam int FW     = wpt_pkg::FRAC_W;
  localparam int MW     = wpt_pkg::MICRO_W;
  localparam int CNW    = wpt_pkg::COUNT_W;
  localparam logic [FW-1:0] FRAC_MAX  = FW'(FRAC_SCALE - 1);
  localparam logic [MW-1:0] SCALE     = MW'(FRAC_SCALE);
  localparam logic [NW:0]   KEY_LIMIT = (NW + 1)'(KEY_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_LAT, S_LON, S_SCAN, S_READ, S_DONE
  } state_t;

  state_t                          state;
  wpt_pkg::kind_t                  kind_q;
  logic [NW-1:0]                   num_q;
  logic [wpt_pkg::WHOLE_W-1:0]     latw_q;
  logic [FW-1:0]                   latf_q;
  logic [wpt_pkg::WHOLE_W-1:0]     lonw_q;
  logic [FW-1:0]                   lonf_q;
  logic [KEY_COUNT-1:0]            present_map;
  logic [NW-1:0]                   cursor;
  logic                            cursor_set;
  logic [CNW-1:0]                  count;
  wpt_pkg::status_t                st_q;
  logic [MW-1:0]                   lat_q;
  logic [MW-1:0]                   lon_q;

  logic [ADDR_W-1:0]               addr;
  logic                            in_range;
  logic                            hit_map;
  logic [wpt_pkg::WHOLE_W-1:0]     mul_whole;
  logic [FW-1:0]                   mul_frac;
  logic [FW-1:0]                   frac_sat;
  logic [MW-1:0]                   micro;
  logic [MW-1:0]                   lat_rdata;
  logic [MW-1:0]                   lon_rdata;
  logic                            scan_start;
  wpt_pkg::scan_res_t              scan_res;

  assign addr     = num_q[ADDR_W-1:0];
  assign in_range = {1'b0, num_q} < KEY_LIMIT;
  assign hit_map  = in_range && present_map[addr];

  always_comb begin
    mul_whole = (state == S_LAT) ? latw_q : lonw_q;
    mul_frac  = (state == S_LAT) ? latf_q : lonf_q;
    frac_sat  = (mul_frac > FRAC_MAX) ? FRAC_MAX : mul_frac;
    micro     = MW'(mul_whole) * SCALE + MW'(frac_sat);
  end

  assign scan_start = (state == S_START) &&
                      (((kind_q == wpt_pkg::KIND_INSERT) && in_range && !hit_map) ||
                       (((kind_q == wpt_pkg::KIND_NEXT) || (kind_q == wpt_pkg::KIND_PREV)) &&
                        (count != '0) && cursor_set));

  wpt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .dir_up (kind_q == wpt_pkg::KIND_NEXT),
    .from   ((kind_q == wpt_pkg::KIND_INSERT) ? num_q : cursor),
    .map    (wpt_pkg::TABLE_SLOTS'(present_map)),
    .result (scan_res)
  );

  wpt_ram #(.WIDTH(MW), .DEPTH(KEY_COUNT)) u_lat_ram (
    .clk   (clk),
    .we    (state == S_LAT),
    .waddr (addr),
    .wdata (micro),
    .raddr (addr),
    .rdata (lat_rdata)
  );

  wpt_ram #(.WIDTH(MW), .DEPTH(KEY_COUNT)) u_lon_ram (
    .clk   (clk),
    .we    (state == S_LON),
    .waddr (addr),
    .wdata (micro),
    .raddr (addr),
    .rdata (lon_rdata)
  );

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      present_map <= '0;
      cursor      <= '0;
      cursor_set  <= 1'b0;
      count       <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != S_DONE)) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind_q <= wpt_pkg::kind_t'(cmd.kind);
            num_q  <= cmd.point_number;
            latw_q <= cmd.lat_whole;
            latf_q <= cmd.lat_millionths;
            lonw_q <= cmd.lon_whole;
            lonf_q <= cmd.lon_millionths;
            state  <= S_START;
          end
        end
        S_START: begin
          lat_q <= '0;
          lon_q <= '0;
          case (kind_q)
            wpt_pkg::KIND_INSERT: begin
              if (!in_range) begin
                st_q  <= wpt_pkg::ST_MISS;
                state <= S_DONE;
              end else if (hit_map) begin
                st_q  <= wpt_pkg::ST_DUP;
                state <= S_DONE;
              end else begin
                st_q  <= wpt_pkg::ST_OK;
                state <= S_LAT;
              end
            end
            wpt_pkg::KIND_LOOKUP: begin
              if (hit_map) begin
                st_q  <= wpt_pkg::ST_OK;
                state <= S_READ;
              end else begin
                st_q  <= wpt_pkg::ST_MISS;
                state <= S_DONE;
              end
            end
            default: begin
              if ((count == '0) || !cursor_set) begin
                st_q  <= wpt_pkg::ST_EMPTY;
                state <= S_DONE;
              end else begin
                st_q  <= wpt_pkg::ST_OK;
                state <= S_SCAN;
              end
            end
          endcase
        end
        S_LAT: begin
          state <= S_LON;
        end
        S_LON: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (kind_q == wpt_pkg::KIND_INSERT) begin
              present_map[addr] <= 1'b1;
              count             <= count + CNW'(1);
              if (!scan_res.found) begin
                cursor     <= num_q;
                cursor_set <= 1'b1;
              end
            end else if (scan_res.found) begin
              cursor <= scan_res.index;
            end else begin
              st_q <= wpt_pkg::ST_END;
            end
            state <= S_DONE;
          end
        end
        S_READ: begin
          lat_q <= lat_rdata;
          lon_q <= lon_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid           <= 1'b1;
            res.status          <= st_q;
            res.latitude_micro  <= lat_q;
            res.longitude_micro <= lon_q;
            res.cursor_number   <= cursor_set ? cursor : '0;
            res.cursor_valid    <= cursor_set;
            res.point_count     <= count;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/wpt_check.sv
// Port-level checks for the waypoint table, bound to the top level.
// Depends on wpt_pkg for status codes.
module wpt_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [wpt_pkg::STATUS_W-1:0]    status,
  input logic [wpt_pkg::MICRO_W-1:0]     latitude_micro,
  input logic [wpt_pkg::MICRO_W-1:0]     longitude_micro,
  input logic                            cursor_valid,
  input logic [wpt_pkg::COUNT_W-1:0]     point_count
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while previous item in progress");

  a_cursor_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (cursor_valid == (point_count != '0)))
    else $error("cursor validity disagrees with stored count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == wpt_pkg::ST_EMPTY) |-> (point_count == '0))
    else $error("empty reported on a non-empty table");

  a_coords_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != wpt_pkg::ST_OK) |->
      (latitude_micro == '0) && (longitude_micro == '0))
    else $error("coordinates reported on a failed item");

endmodule

bind waypoint_table_with_cursor wpt_check u_wpt_check (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .status          (res.status),
  .latitude_micro  (res.latitude_micro),
  .longitude_micro (res.longitude_micro),
  .cursor_valid    (res.cursor_valid),
  .point_count     (res.point_count)
);
